FILE: sv/hed_pkg.sv
`timescale 1ns / 1ps
// hed_pkg: shared types, character codes and the reference name table of the entity decoder
package hed_pkg;

  localparam int unsigned WIN_BYTES  = 11;
  localparam int unsigned WIN_LAST   = 10;
  localparam int unsigned NAME_COUNT = 29;
  localparam int unsigned NAME_MAX   = 6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  // names are right-aligned in the vector, first character highest
  localparam logic [8*NAME_MAX-1:0] NAME_TEXT [NAME_COUNT] = '{
    "amp", "lt", "gt", "quot", "apos", "nbsp",
    "auml", "ouml", "uuml", "Auml", "Ouml", "Uuml",
    "szlig", "eacute", "egrave", "copy", "reg", "deg",
    "euro", "mdash", "ndash", "hellip", "laquo", "raquo",
    "bdquo", "ldquo", "rdquo", "lsquo", "rsquo"
  };

  localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd6, 3'd6, 3'd4, 3'd3, 3'd3,
    3'd4, 3'd5, 3'd5, 3'd6, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [7:0] NAME_CODE [NAME_COUNT] = '{
    8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20,
    8'hE4, 8'hF6, 8'hFC, 8'hC4, 8'hD6, 8'hDC,
    8'hDF, 8'hE9, 8'hE8, 8'hA9, 8'hAE, 8'hB0,
    8'h80, 8'h2D, 8'h2D, 8'h2E, 8'h22, 8'h22,
    8'h22, 8'h22, 8'h22, 8'h27, 8'h27
  };

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hed_dig_t;

  // one window in flight through the cell row
  typedef struct packed {
    logic [WIN_BYTES-1:0][7:0] win;
    logic                      run;    // still scanning for ';'
    logic                      hit;    // ';' found, no error so far
    logic [3:0]                semi;   // offset of the ';'
    logic                      num;    // numeric reference
    logic                      hex;    // hex base selected
    logic                      big;    // value reached 256 or more
    logic [7:0]                val;    // low value bits
    logic [NAME_COUNT-1:0]     match;  // table entries still matching
  } hed_tok_t;

  function automatic logic [7:0] name_char(input int unsigned e, input int unsigned i);
    logic [7:0] c;
    c = CH_NUL;
    if (i < NAME_LEN[e]) begin
      c = NAME_TEXT[e][(NAME_LEN[e] - 1 - i) * 8 +: 8];
    end
    return c;
  endfunction

  function automatic hed_dig_t hed_digit(input logic [7:0] b);
    hed_dig_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    if (b >= CH_0 && b <= CH_9) begin
      r.ok  = 1'b1;
      r.val = 4'(b - CH_0);
    end else if (b >= CH_LA && b <= CH_LF) begin
      r.ok  = 1'b1;
      r.val = 4'(b - CH_LA + 8'd10);
    end else if (b >= CH_UA && b <= CH_UF) begin
      r.ok  = 1'b1;
      r.val = 4'(b - CH_UA + 8'd10);
    end
    return r;
  endfunction

endpackage

FILE: sv/hed_cell.sv
`timescale 1ns / 1ps
// hed_cell: one cell of the scan row, examines the window byte at offset POS
module hed_cell import hed_pkg::*; #(
  parameter int unsigned POS = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  hed_tok_t in_tok_i,
  output logic     ready_o,
  input  logic     down_ready_i,
  output logic     valid_o,
  output hed_tok_t tok_o
);

  logic       valid_q;
  hed_tok_t   tok_q, tok_d;
  logic [7:0] b;
  hed_dig_t   dig;
  logic [11:0] acc;

  assign ready_o = !valid_q || down_ready_i;

  always_comb begin
    tok_d = in_tok_i;
    b     = in_tok_i.win[POS];
    dig   = hed_digit(b);
    if (in_tok_i.hex) begin
      acc = {in_tok_i.val, 4'h0} + {8'h00, dig.val};
    end else begin
      acc = {1'b0, in_tok_i.val, 3'b000} + {3'b000, in_tok_i.val, 1'b0} + {8'h00, dig.val};
    end
    if (POS == 0) begin
      tok_d.run   = (b == CH_AMP);
      tok_d.hit   = 1'b0;
      tok_d.semi  = 4'd0;
      tok_d.num   = 1'b0;
      tok_d.hex   = 1'b0;
      tok_d.big   = 1'b0;
      tok_d.val   = 8'd0;
      tok_d.match = '1;
    end else if (in_tok_i.run) begin
      if (b == CH_SEMI) begin
        tok_d.run  = 1'b0;
        tok_d.hit  = 1'b1;
        tok_d.semi = 4'(POS);
        // name length must equal the entry length exactly
        for (int e = 0; e < NAME_COUNT; e++) begin
          tok_d.match[e] = in_tok_i.match[e] && (32'(NAME_LEN[e]) == POS - 1);
        end
      end else if (b == CH_NUL) begin
        tok_d.run = 1'b0;
      end else begin
        for (int e = 0; e < NAME_COUNT; e++) begin
          tok_d.match[e] = in_tok_i.match[e] && (name_char(e, POS - 1) == b) &&
                           (POS - 1 < 32'(NAME_LEN[e]));
        end
        if (POS == 1) begin
          tok_d.num = (b == CH_HASH);
        end else if (in_tok_i.num) begin
          if (POS == 2 && (b == CH_LX || b == CH_UX)) begin
            tok_d.hex = 1'b1;
          end else if (!dig.ok) begin
            tok_d.run = 1'b0;
          end else begin
            tok_d.val = acc[7:0];
            tok_d.big = in_tok_i.big || (acc[11:8] != 4'd0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

FILE: sv/hed_out.sv
`timescale 1ns / 1ps
// hed_out: resolves the scan outcome into consumed count and decoded byte, output register
module hed_out import hed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  hed_tok_t   in_tok_i,
  output logic       ready_o,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [3:0] consumed_o,
  output logic [7:0] char_o
);

  logic       valid_q;
  logic [3:0] consumed_q, consumed_d;
  logic [7:0] char_q, char_d;
  logic [7:0] code;
  logic       found;

  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    code = CH_NUL;
    for (int e = 0; e < NAME_COUNT; e++) begin
      if (in_tok_i.match[e]) begin
        code = code | NAME_CODE[e];
      end
    end
    found      = in_tok_i.hit && (in_tok_i.num || (|in_tok_i.match));
    consumed_d = found ? in_tok_i.semi + 4'd1 : 4'd0;
    if (!found) begin
      char_d = CH_NUL;
    end else if (in_tok_i.num) begin
      char_d = (!in_tok_i.big && in_tok_i.val != 8'd0) ? in_tok_i.val : CH_QMARK;
    end else begin
      char_d = code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      consumed_q <= consumed_d;
      char_q     <= char_d;
    end
  end

  assign valid_o    = valid_q;
  assign consumed_o = consumed_q;
  assign char_o     = char_q;

endmodule

FILE: sv/html_entity_decoder_core.sv
`timescale 1ns / 1ps
// html_entity_decoder_core: top level, row of scan cells plus output register
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------
//   in      | sink      | in_valid_i / in_stall_o   | win_0_i .. win_10_i
//   out     | source    | out_valid_o / out_stall_i | consumed_o, decoded_char_o
//
// one transaction per clock sustained while out_stall_i is low; a window passes through
// one cell per window offset 0 .. SPAN and then the output register
// each cell holds one window and hands it on while taking the next, so a
// stalled output only fills bubbles in the row before stalling the input
// reset clears all valid flags; window payload registers are not reset
module html_entity_decoder_core import hed_pkg::*; #(
  parameter int unsigned MAX_SPAN = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] win_0_i,
  input  logic [7:0] win_1_i,
  input  logic [7:0] win_2_i,
  input  logic [7:0] win_3_i,
  input  logic [7:0] win_4_i,
  input  logic [7:0] win_5_i,
  input  logic [7:0] win_6_i,
  input  logic [7:0] win_7_i,
  input  logic [7:0] win_8_i,
  input  logic [7:0] win_9_i,
  input  logic [7:0] win_10_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] consumed_o,
  output logic [7:0] decoded_char_o
);

  // ';' may stand no later than the window end
  localparam int unsigned SPAN  = (MAX_SPAN < WIN_LAST) ? MAX_SPAN : WIN_LAST;
  localparam int unsigned CELLS = SPAN + 1;

  hed_tok_t in_tok;
  hed_tok_t tok   [CELLS];
  logic     vld   [CELLS];
  logic     rdy   [CELLS];
  logic     out_rdy;

  // incoming window, scan flags are set up by cell zero
  always_comb begin
    in_tok      = '0;
    in_tok.win  = {win_10_i, win_9_i, win_8_i, win_7_i, win_6_i, win_5_i,
                   win_4_i, win_3_i, win_2_i, win_1_i, win_0_i};
  end

  assign in_stall_o = !rdy[0];

  // cell k checks window offset k
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    hed_cell #(
      .POS(k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  ((k == 0) ? in_valid_i : vld[(k == 0) ? 0 : k - 1]),
      .in_tok_i    ((k == 0) ? in_tok : tok[(k == 0) ? 0 : k - 1]),
      .ready_o     (rdy[k]),
      .down_ready_i((k == CELLS - 1) ? out_rdy : rdy[(k == CELLS - 1) ? k : k + 1]),
      .valid_o     (vld[k]),
      .tok_o       (tok[k])
    );
  end

  // result resolve and output register
  hed_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(vld[CELLS - 1]),
    .in_tok_i  (tok[CELLS - 1]),
    .ready_o   (out_rdy),
    .valid_o   (out_valid_o),
    .stall_i   (out_stall_i),
    .consumed_o(consumed_o),
    .char_o    (decoded_char_o)
  );

  // a decoded byte is zero exactly when nothing was consumed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((consumed_o == 4'd0) == (decoded_char_o == 8'd0)))
    else $error("decoded byte and consumed count disagree");

  // shortest reference is three bytes, longest ends at the span limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (consumed_o == 4'd0 ||
                     (consumed_o >= 4'd3 && 32'(consumed_o) <= SPAN + 1)))
    else $error("consumed count out of range");

  // a new result only comes from a window held in the last cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld[CELLS - 1]))
    else $error("result appeared without a window in the last cell");

endmodule
